FILE: hdl/tkf_pkg.sv
// shared types, constants and the cordic arctangent table for the tilt filter
package tkf_pkg;

    localparam int STEP_W     = 5;
    localparam int ATAN_LEN   = 24;
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 16;

    localparam logic signed [17:0] RIGHT_ANGLE = 18'sd23040;
    localparam logic signed [31:0] ANGLE_LIMIT = 32'sd46080;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SQINIT, S_PRED, S_DENOM, S_SQRT, S_CINIT,
        S_CORDIC, S_DIV0, S_DIV, S_CMUL, S_CADD, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        REG_X_OFF, REG_Y_OFF, REG_Z_OFF, REG_PERIOD, REG_GYRO_SD, REG_ACCEL_SD
    } t_reg_idx;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              sq_init;
        logic              pred;
        logic              denom;
        logic              sqrt_step;
        logic              c_init;
        logic              c_step;
        logic              div_init;
        logic              div_step;
        logic              c_mul;
        logic              c_add;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic signed [12:0] x_off;
        logic signed [12:0] y_off;
        logic signed [12:0] z_off;
        logic [15:0]        period;
        logic [7:0]         gyro_sd;
        logic [7:0]         accel_sd;
    } t_cfg;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_deg16(input logic [STEP_W-1:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/tkf_ctrl.sv
// sequencer for the tilt filter: steps the datapath through one sample
module tkf_ctrl #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tkf_pkg::t_cmd o_cmd
);

    localparam int NStage = (CORDIC_STAGES > tkf_pkg::ATAN_LEN) ? tkf_pkg::ATAN_LEN :
                            ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

    tkf_pkg::t_state             r_state, n_state;
    logic [tkf_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.step  = r_cnt;
        o_in_ready  = (r_state == tkf_pkg::S_IDLE);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            tkf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tkf_pkg::S_MUL;
                end
            end
            tkf_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = tkf_pkg::S_SQINIT;
            end
            tkf_pkg::S_SQINIT: begin
                o_cmd.sq_init = 1'b1;
                n_state       = tkf_pkg::S_PRED;
            end
            tkf_pkg::S_PRED: begin
                o_cmd.pred = 1'b1;
                n_state    = tkf_pkg::S_DENOM;
            end
            tkf_pkg::S_DENOM: begin
                o_cmd.denom = 1'b1;
                n_cnt       = '0;
                n_state     = tkf_pkg::S_SQRT;
            end
            tkf_pkg::S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == tkf_pkg::STEP_W'(tkf_pkg::SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = tkf_pkg::S_CINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tkf_pkg::S_CINIT: begin
                o_cmd.c_init = 1'b1;
                n_cnt        = '0;
                n_state      = tkf_pkg::S_CORDIC;
            end
            tkf_pkg::S_CORDIC: begin
                o_cmd.c_step = 1'b1;
                if (r_cnt == tkf_pkg::STEP_W'(NStage - 1)) begin
                    n_cnt   = '0;
                    n_state = tkf_pkg::S_DIV0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tkf_pkg::S_DIV0: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = tkf_pkg::S_DIV;
            end
            tkf_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == tkf_pkg::STEP_W'(tkf_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = tkf_pkg::S_CMUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tkf_pkg::S_CMUL: begin
                o_cmd.c_mul = 1'b1;
                n_state     = tkf_pkg::S_CADD;
            end
            tkf_pkg::S_CADD: begin
                o_cmd.c_add = 1'b1;
                n_state     = tkf_pkg::S_DONE;
            end
            tkf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = tkf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tkf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/tkf_dp.sv
// datapath of the tilt filter: square root, cordic, kalman update and divider
module tkf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkf_pkg::t_cmd      i_cmd,
    input  tkf_pkg::t_cfg      i_cfg,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_rate,
    output logic signed [16:0] o_angle
);

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // sample and products
    logic signed [17:0] r_ax, r_ay, r_az;
    logic signed [15:0] r_rate;
    logic [31:0]        r_sqx, r_sqz;
    logic signed [32:0] r_rp;
    logic [15:0]        r_g2, r_a2;
    logic [31:0]        r_pg;
    // square root
    logic [31:0]        r_n, r_root, r_bit;
    // cordic
    logic signed [35:0] r_cx, r_cy;
    logic signed [24:0] r_z;
    logic signed [17:0] r_pitch;
    // gain division
    logic [32:0]        r_denom;
    logic [33:0]        r_rem;
    logic [16:0]        r_gain;
    logic               r_dz;
    // correction
    logic signed [32:0] r_diff;
    logic signed [50:0] r_kd;
    logic [47:0]        r_kp;
    // filter state
    logic signed [31:0] r_est;
    logic [31:0]        r_p;
    logic signed [16:0] r_angle;

    logic signed [35:0] w_sqx, w_sqz;
    logic signed [32:0] w_rp, w_rp_r, w_rp_s;
    logic [31:0]        w_pg;
    logic signed [35:0] w_est_p;
    logic [32:0]        w_pgrow;
    logic [31:0]        w_trial;
    logic signed [35:0] w_dx, w_dy;
    logic signed [24:0] w_at;
    logic signed [24:0] w_zr;
    logic [34:0]        w_t;
    logic               w_qbit;
    logic [16:0]        w_ng;
    logic [48:0]        w_kp;
    logic signed [50:0] w_kd, w_kdr, w_kds;
    logic signed [35:0] w_est_c;

    assign w_sqx   = r_ax * r_ax;
    assign w_sqz   = r_az * r_az;
    assign w_rp    = r_rate * $signed({1'b0, i_cfg.period});
    assign w_pg    = i_cfg.period * r_g2;
    assign w_rp_r  = r_rp + 33'sd2048;
    assign w_rp_s  = w_rp_r >>> 12;
    assign w_est_p = r_est + w_rp_s;
    assign w_pgrow = {1'b0, r_p} + {1'b0, r_pg};
    assign w_trial = r_root + r_bit;
    assign w_dx    = r_cy >>> i_cmd.step;
    assign w_dy    = r_cx >>> i_cmd.step;
    assign w_at    = $signed({3'b000, tkf_pkg::atan_deg16(i_cmd.step)});
    assign w_zr    = (r_z + 25'sd128) >>> 8;
    assign w_t     = {r_rem, 1'b0};
    assign w_qbit  = !r_dz && (w_t >= {2'b00, r_denom});
    assign w_ng    = 17'h1_0000 - r_gain;
    assign w_kp    = w_ng * r_p;
    assign w_kd    = $signed({1'b0, r_gain}) * r_diff;
    assign w_kdr   = r_kd + 51'sd32768;
    assign w_kds   = w_kdr >>> 16;
    assign w_est_c = r_est + $signed(w_kds[35:0]);

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_p   <= '0;
        end else if (i_cmd.pred) begin
            r_est <= sat32(w_est_p);
            r_p   <= w_pgrow[32] ? 32'hFFFF_FFFF : w_pgrow[31:0];
        end else if (i_cmd.c_add) begin
            r_est <= sat32(w_est_c);
            r_p   <= r_kp[47:16];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax   <= $signed({{2{i_accel_x[15]}}, i_accel_x})
                    + $signed({{5{i_cfg.x_off[12]}}, i_cfg.x_off});
            r_ay   <= $signed({{2{i_accel_y[15]}}, i_accel_y})
                    + $signed({{5{i_cfg.y_off[12]}}, i_cfg.y_off});
            r_az   <= $signed({{2{i_accel_z[15]}}, i_accel_z})
                    + $signed({{5{i_cfg.z_off[12]}}, i_cfg.z_off});
            r_rate <= i_gyro_rate;
        end
        if (i_cmd.mul) begin
            r_sqx <= w_sqx[31:0];
            r_sqz <= w_sqz[31:0];
            r_rp  <= w_rp;
            r_g2  <= i_cfg.gyro_sd * i_cfg.gyro_sd;
            r_a2  <= i_cfg.accel_sd * i_cfg.accel_sd;
        end
        if (i_cmd.sq_init) begin
            r_n    <= r_sqx + r_sqz;
            r_root <= '0;
            r_bit  <= 32'h4000_0000;
            r_pg   <= w_pg;
        end
        if (i_cmd.denom) begin
            r_denom <= {1'b0, r_p} + {1'b0, r_a2, 16'h0000};
            r_rem   <= {2'b00, r_p};
        end
        if (i_cmd.sqrt_step) begin
            if (r_n >= w_trial) begin
                r_n    <= r_n - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.c_init) begin
            r_cx <= $signed({4'b0000, r_root[15:0], 16'h0000});
            r_cy <= $signed({{2{r_ay[17]}}, r_ay, 16'h0000});
            r_z  <= '0;
        end
        if (i_cmd.c_step) begin
            if (!r_cy[35]) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_z  <= r_z + w_at;
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_z  <= r_z - w_at;
            end
        end
        if (i_cmd.div_init) begin
            // both horizontal axes zero: pitch follows the sign of y
            if (r_ax == 18'sd0 && r_az == 18'sd0) begin
                if (r_ay > 18'sd0) begin
                    r_pitch <= tkf_pkg::RIGHT_ANGLE;
                end else if (r_ay < 18'sd0) begin
                    r_pitch <= -tkf_pkg::RIGHT_ANGLE;
                end else begin
                    r_pitch <= '0;
                end
            end else begin
                r_pitch <= w_zr[17:0];
            end
            r_dz <= (r_denom == '0);
            if (r_denom != '0 && r_rem >= {1'b0, r_denom}) begin
                r_rem  <= r_rem - {1'b0, r_denom};
                r_gain <= 17'd1;
            end else begin
                r_gain <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? 34'(w_t - {2'b00, r_denom}) : w_t[33:0];
            r_gain <= {r_gain[15:0], w_qbit};
            r_diff <= r_pitch - r_est;
        end
        if (i_cmd.c_mul) begin
            r_kd <= w_kd;
            r_kp <= w_kp[47:0];
        end
        if (i_cmd.out_load) begin
            if (r_est > tkf_pkg::ANGLE_LIMIT) begin
                r_angle <= 17'(tkf_pkg::ANGLE_LIMIT);
            end else if (r_est < -tkf_pkg::ANGLE_LIMIT) begin
                r_angle <= 17'(-tkf_pkg::ANGLE_LIMIT);
            end else begin
                r_angle <= r_est[16:0];
            end
        end
    end

    assign o_angle = r_angle;

endmodule

FILE: hdl/tilt_kalman_fusion.sv
// top level of the accelerometer and gyro tilt filter
//
//  channel  | valid / ready           | word
//  ---------+-------------------------+------------------------------------------
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  sample   | i_valid / o_ready       | i_accel_x, i_accel_y, i_accel_z, i_gyro_rate
//  result   | o_valid / i_ready       | o_angle
//
// one sample goes from acceptance to result through 16 square root steps,
// CORDIC_STAGES cordic steps (clamped to 1..24 stages) at one per cycle and
// 17 gain divider steps, each through a single shared unit
// a new sample is taken only once the last has reached its result, and it
// can be taken in the same cycle as that result appears
// reset clears the state machine, filter estimate and uncertainty, and loads
// the register defaults; a result waiting on i_ready does not stop the next
// sample being taken, only the final hand-over of that next sample's result
module tilt_kalman_fusion #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // sample
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_rate,
    // result
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_angle
);

    tkf_pkg::t_cfg r_cfg;
    tkf_pkg::t_cmd w_cmd;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_off    <= -13'sd205;
            r_cfg.y_off    <= 13'sd41;
            r_cfg.z_off    <= 13'sd41;
            r_cfg.period   <= 16'd262;
            r_cfg.gyro_sd  <= 8'd6;
            r_cfg.accel_sd <= 8'd8;
        end else if (i_cfg_valid) begin
            unique case (tkf_pkg::t_reg_idx'(i_cfg_index))
                tkf_pkg::REG_X_OFF:    r_cfg.x_off    <= i_cfg_data[12:0];
                tkf_pkg::REG_Y_OFF:    r_cfg.y_off    <= i_cfg_data[12:0];
                tkf_pkg::REG_Z_OFF:    r_cfg.z_off    <= i_cfg_data[12:0];
                tkf_pkg::REG_PERIOD:   r_cfg.period   <= i_cfg_data;
                tkf_pkg::REG_GYRO_SD:  r_cfg.gyro_sd  <= i_cfg_data[7:0];
                tkf_pkg::REG_ACCEL_SD: r_cfg.accel_sd <= i_cfg_data[7:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // sequencer
    tkf_ctrl #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic and filter state
    tkf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_gyro_rate (i_gyro_rate),
        .o_angle     (o_angle)
    );

endmodule
